// ===== hw/rtl/cbp_pkg.sv =====
// Shared types and constants for the CRC codeword byte packer.
// No dependencies; every other file but cbp_queue refers to this package by scoped names.
package cbp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_GEN_BITS_DEF = 17;
    localparam int LENGTH_BITS_DEF  = 16;

    // Fixed sizes
    localparam int GLEN_W       = 5;    // gen_length register width
    localparam int MAX_RESULTS  = 8;    // bytes kept per request, rest dropped
    localparam int QUEUE_DEPTH  = 4;    // entries between front and back

    // Register reset values
    localparam int GEN_POLY_RST = 13;
    localparam int GEN_LEN_RST  = 4;
    localparam int MSG_LEN_RST  = 1;

    // Register map, in word steps
    typedef enum logic [1:0] {
        REG_GEN_POLY  = 2'd0,
        REG_GEN_LEN   = 2'd1,
        REG_DW_MODE   = 2'd2,
        REG_MSG_BYTES = 2'd3
    } t_reg_idx;

    // Control part of one queued request
    typedef struct packed {
        logic       hdr;    // request opens a message: send pad header first
        logic [3:0] pad;    // pad count, 1..8
        logic       ends;   // request closes the message
    } t_ctl;

endpackage

// ===== hw/rtl/cbp_queue.sv =====
// Short first-in first-out queue between the front and the back.
// Register array with head and tail pointers; depends on nothing else.
module cbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count,  n_count;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + (AW+1)'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == (AW+1)'(DEPTH));

endmodule

// ===== hw/rtl/cbp_front.sv =====
// Front end: computes CRC remainders for one message byte, the pad header
// and the end of message, and builds the bit string for the back end.
// Depends on cbp_pkg.
module cbp_front #(
    parameter int MAX_GEN_BITS = cbp_pkg::MAX_GEN_BITS_DEF,
    parameter int LENGTH_BITS  = cbp_pkg::LENGTH_BITS_DEF,
    parameter int PAYW         = 16 + 2 * (MAX_GEN_BITS - 1),
    parameter int LENW         = $clog2(PAYW + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_data_byte,
    input  logic [MAX_GEN_BITS-1:0]  i_generator_poly,
    input  logic [cbp_pkg::GLEN_W-1:0] i_gen_length,
    input  logic                     i_dataword_mode,
    input  logic [LENGTH_BITS-1:0]   i_message_bytes,
    output cbp_pkg::t_ctl            o_ctl,
    output logic [LENW-1:0]          o_len,
    output logic [PAYW-1:0]          o_bits
);

    localparam int RMAX = MAX_GEN_BITS - 1;
    localparam int RW   = $clog2(MAX_GEN_BITS);

    // One nibble through the division, remainder kept left-aligned
    function automatic logic [RMAX-1:0] rem_nib(input logic [RMAX-1:0] rem_in,
                                                input logic [3:0]      nib,
                                                input logic [RMAX-1:0] gen_al);
        logic [RMAX-1:0] rem;
        logic            fb;
        rem = rem_in;
        for (int i = 3; i >= 0; i--) begin
            fb  = rem[RMAX-1] ^ nib[i];
            rem = rem << 1;
            if (fb) begin
                rem = rem ^ gen_al;
            end
        end
        return rem;
    endfunction

    logic [LENGTH_BITS-1:0] r_rcv, n_rcv;
    logic [RW:0]            g_eff;
    logic [RW-1:0]          rem_len;
    logic [RMAX-1:0]        mask_r, gen_al;
    logic [RW-1:0]          align;
    logic [RMAX-1:0]        rem_hi, rem_lo, rem_b8;
    logic [PAYW-1:0]        cw8, cw_hi, cw_lo, cw4;
    logic [5:0]             prod;
    logic [2:0]             p3;
    logic [3:0]             pad;
    logic                   hdr, ends;
    logic [LENGTH_BITS-1:0] rcv_next;
    logic [LENW-1:0]        rem_len_w;

    // Clamp the generator length and align the generator to the top
    always_comb begin
        if (32'(i_gen_length) < 32'd2) begin
            g_eff = (RW+1)'(2);
        end else if (32'(i_gen_length) > 32'(MAX_GEN_BITS)) begin
            g_eff = (RW+1)'(MAX_GEN_BITS);
        end else begin
            g_eff = (RW+1)'(i_gen_length);
        end
        rem_len = RW'(g_eff - (RW+1)'(1));
        mask_r  = ~({RMAX{1'b1}} << rem_len);
        align   = RW'(RMAX) - rem_len;
        gen_al  = (i_generator_poly[RMAX-1:0] & mask_r) << align;
    end

    // Remainders: each nibble alone, and the whole byte
    always_comb begin
        rem_hi = rem_nib('0, i_data_byte[7:4], gen_al);
        rem_lo = rem_nib('0, i_data_byte[3:0], gen_al);
        rem_b8 = rem_nib(rem_hi, i_data_byte[3:0], gen_al);
    end

    // Build codewords, right-aligned
    always_comb begin
        rem_len_w = LENW'(rem_len);
        cw8   = (PAYW'(i_data_byte) << rem_len) | PAYW'(rem_b8 >> align);
        cw_hi = (PAYW'(i_data_byte[7:4]) << rem_len) | PAYW'(rem_hi >> align);
        cw_lo = (PAYW'(i_data_byte[3:0]) << rem_len) | PAYW'(rem_lo >> align);
        cw4   = (cw_hi << (rem_len_w + LENW'(4))) | cw_lo;
    end

    // Pad count from the low bits of the message's codeword bit total
    always_comb begin
        prod = 6'(i_message_bytes[2:0] * 3'(rem_len));
        p3   = i_dataword_mode ? prod[2:0] : {prod[1:0], 1'b0};
        pad  = 4'd8 - {1'b0, p3};
    end

    // Track position within the message
    always_comb begin
        hdr      = (r_rcv == '0);
        rcv_next = r_rcv + LENGTH_BITS'(1);
        ends     = (rcv_next == i_message_bytes);
        n_rcv    = r_rcv;
        if (i_accept) begin
            n_rcv = ends ? '0 : rcv_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcv <= '0;
        end else begin
            r_rcv <= n_rcv;
        end
    end

    // Hand the request over; the pad zeros lead as unset high bits
    always_comb begin
        o_ctl.hdr  = hdr;
        o_ctl.pad  = pad;
        o_ctl.ends = ends;
        o_bits     = i_dataword_mode ? cw8 : cw4;
        o_len      = (hdr ? LENW'(pad) : '0) + LENW'(8) +
                     (i_dataword_mode ? rem_len_w : (rem_len_w << 1));
    end

endmodule

// ===== hw/rtl/cbp_back.sv =====
// Back end: bit accumulator that emits the header and packed codeword bytes,
// one per cycle while i_stall is low, through an output register. Depends on cbp_pkg.
module cbp_back #(
    parameter int PAYW = 48,
    parameter int LENW = $clog2(PAYW + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  cbp_pkg::t_ctl   i_ctl,
    input  logic [LENW-1:0] i_len,
    input  logic [PAYW-1:0] i_bits,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_is_header,
    output logic            o_last_of_run,
    output logic            o_message_end
);

    localparam int ACCW  = PAYW + 7;
    localparam int PENDW = $clog2(ACCW + 1);
    localparam int CNTW  = $clog2(cbp_pkg::MAX_RESULTS + 1);

    logic [ACCW-1:0]  r_acc, n_acc;
    logic [PENDW-1:0] r_pend, n_pend;
    logic             r_busy, n_busy;
    logic             r_hdr, n_hdr;
    logic [3:0]       r_pad, n_pad;
    logic             r_ends, n_ends;
    logic [CNTW-1:0]  r_cnt, n_cnt;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_hdr, n_out_hdr;
    logic             r_out_last, n_out_last;
    logic             r_out_end, n_out_end;

    logic             out_free, emit, more, cap, last, finish;
    logic [7:0]       byte_sel;
    logic [PENDW-1:0] pend_after, pend_fin, pend_base;

    // Pick the next byte: header, a full byte, or the zero-filled tail
    always_comb begin
        if (r_hdr) begin
            byte_sel   = 8'(r_pad);
            pend_after = r_pend;
        end else if (r_pend >= PENDW'(8)) begin
            byte_sel   = 8'(r_acc >> (r_pend - PENDW'(8)));
            pend_after = r_pend - PENDW'(8);
        end else begin
            byte_sel   = 8'(r_acc[7:0] << (4'd8 - {1'b0, r_pend[2:0]}));
            pend_after = '0;
        end
        more = (pend_after >= PENDW'(8)) || (r_ends && (pend_after != '0));
        cap  = (r_cnt == CNTW'(cbp_pkg::MAX_RESULTS - 1));
        last = !more || cap;
        if (r_ends) begin
            pend_fin = '0;
        end else if (cap) begin
            pend_fin = PENDW'(pend_after[2:0]);
        end else begin
            pend_fin = pend_after;
        end
    end

    // Handshake and next state
    always_comb begin
        out_free  = !r_out_valid || !i_stall;
        emit      = r_busy && out_free;
        finish    = emit && last;
        o_pop     = i_avail && (!r_busy || finish);
        pend_base = finish ? pend_fin : r_pend;

        n_acc  = r_acc;
        n_pend = r_pend;
        n_busy = r_busy;
        n_hdr  = r_hdr;
        n_pad  = r_pad;
        n_ends = r_ends;
        n_cnt  = r_cnt;
        if (o_pop) begin
            n_busy = 1'b1;
            n_acc  = (r_acc << i_len) | ACCW'(i_bits);
            n_pend = pend_base + PENDW'(i_len);
            n_hdr  = i_ctl.hdr;
            n_pad  = i_ctl.pad;
            n_ends = i_ctl.ends;
            n_cnt  = '0;
        end else if (finish) begin
            n_busy = 1'b0;
            n_pend = pend_fin;
            n_hdr  = 1'b0;
        end else if (emit) begin
            n_pend = pend_after;
            n_hdr  = 1'b0;
            n_cnt  = r_cnt + CNTW'(1);
        end

        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_hdr   = r_out_hdr;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = byte_sel;
            n_out_hdr   = r_hdr;
            n_out_last  = last;
            n_out_end   = last && r_ends;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= '0;
            r_hdr       <= 1'b0;
            r_ends      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pend      <= n_pend;
            r_hdr       <= n_hdr;
            r_ends      <= n_ends;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload state
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_pad      <= n_pad;
        r_out_byte <= n_out_byte;
        r_out_hdr  <= n_out_hdr;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_header   = r_out_hdr;
    assign o_last_of_run = r_out_last;
    assign o_message_end = r_out_end;

endmodule

// ===== hw/rtl/crc_codeword_byte_packer.sv =====
// Top level of the CRC codeword byte packer: register port, front end,
// request queue and back end. Depends on cbp_pkg, cbp_front, cbp_queue, cbp_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  input    | in        | i_valid / o_stall  | i_data_byte
//  result   | out       | o_valid / i_stall  | o_out_byte, o_is_header,
//           |           |                    | o_last_of_run, o_message_end
//  config   | in        | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// Each message byte produces one to seven result bytes at the default generator
// width, the header included, and never more than eight; the result port moves one
// byte a cycle while i_stall is low. Reset is synchronous, active low.
// Input bytes are taken every cycle while the four-entry request queue has room;
// o_stall is high only when it is full. Once the back end is free, the first result
// passes the queue, the back-end accumulator and the output register.
module crc_codeword_byte_packer #(
    parameter int MAX_GEN_BITS = cbp_pkg::MAX_GEN_BITS_DEF,
    parameter int LENGTH_BITS  = cbp_pkg::LENGTH_BITS_DEF,
    parameter int PDW          = (MAX_GEN_BITS > 32 || LENGTH_BITS > 32) ? 64 : 32,
    parameter int ADDR_LSB     = (PDW == 64) ? 3 : 2,
    parameter int PAW          = ADDR_LSB + 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input channel
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_data_byte,
    // result channel
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_is_header,
    output logic           o_last_of_run,
    output logic           o_message_end,
    // register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready
);

    localparam int PAYW = 16 + 2 * (MAX_GEN_BITS - 1);
    localparam int LENW = $clog2(PAYW + 1);
    localparam int CTLW = $bits(cbp_pkg::t_ctl);
    localparam int QW   = CTLW + LENW + PAYW;

    logic [MAX_GEN_BITS-1:0]      r_gen_poly;
    logic [cbp_pkg::GLEN_W-1:0]   r_gen_len;
    logic                         r_dw_mode;
    logic [LENGTH_BITS-1:0]       r_msg_bytes;

    cbp_pkg::t_reg_idx            reg_idx;
    logic                         cfg_wr;
    logic                         accept;

    cbp_pkg::t_ctl                f_ctl, b_ctl;
    logic [LENW-1:0]              f_len, b_len;
    logic [PAYW-1:0]              f_bits, b_bits;
    logic [QW-1:0]                q_rd_data;
    logic                         q_empty, q_full, q_pop;

    // Register port: decode and write
    assign pready  = 1'b1;
    assign reg_idx = cbp_pkg::t_reg_idx'(paddr[ADDR_LSB +: 2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_poly  <= MAX_GEN_BITS'(cbp_pkg::GEN_POLY_RST);
            r_gen_len   <= cbp_pkg::GLEN_W'(cbp_pkg::GEN_LEN_RST);
            r_dw_mode   <= 1'b0;
            r_msg_bytes <= LENGTH_BITS'(cbp_pkg::MSG_LEN_RST);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                cbp_pkg::REG_GEN_POLY:  r_gen_poly  <= pwdata[MAX_GEN_BITS-1:0];
                cbp_pkg::REG_GEN_LEN:   r_gen_len   <= pwdata[cbp_pkg::GLEN_W-1:0];
                cbp_pkg::REG_DW_MODE:   r_dw_mode   <= pwdata[0];
                cbp_pkg::REG_MSG_BYTES: r_msg_bytes <= pwdata[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register port: read back
    always_comb begin
        unique case (reg_idx)
            cbp_pkg::REG_GEN_POLY:  prdata = PDW'(r_gen_poly);
            cbp_pkg::REG_GEN_LEN:   prdata = PDW'(r_gen_len);
            cbp_pkg::REG_DW_MODE:   prdata = PDW'(r_dw_mode);
            cbp_pkg::REG_MSG_BYTES: prdata = PDW'(r_msg_bytes);
            default:                prdata = '0;
        endcase
    end

    // Take a byte whenever the queue has room
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    cbp_front #(
        .MAX_GEN_BITS (MAX_GEN_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .PAYW         (PAYW),
        .LENW         (LENW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_generator_poly (r_gen_poly),
        .i_gen_length     (r_gen_len),
        .i_dataword_mode  (r_dw_mode),
        .i_message_bytes  (r_msg_bytes),
        .o_ctl            (f_ctl),
        .o_len            (f_len),
        .o_bits           (f_bits)
    );

    cbp_queue #(
        .WIDTH (QW),
        .DEPTH (cbp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_data ({f_ctl, f_len, f_bits}),
        .i_rd      (q_pop),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    // Split the head entry
    assign b_ctl  = cbp_pkg::t_ctl'(q_rd_data[QW-1 -: CTLW]);
    assign b_len  = q_rd_data[PAYW +: LENW];
    assign b_bits = q_rd_data[PAYW-1:0];

    cbp_back #(
        .PAYW (PAYW),
        .LENW (LENW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (!q_empty),
        .i_ctl         (b_ctl),
        .i_len         (b_len),
        .i_bits        (b_bits),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_is_header   (o_is_header),
        .o_last_of_run (o_last_of_run),
        .o_message_end (o_message_end)
    );

endmodule

// ===== tb/cbp_checker.sv =====
// Checker for the CRC codeword byte packer: follows register writes and input
// requests, predicts the packed bytes and compares them with the result channel.
// Depends on cbp_pkg for register indexes, result limit and reset values.
module cbp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_data,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_is_header,
    input  logic        i_last_of_run,
    input  logic        i_message_end,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    // status
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       hdr;
        logic       last;
        logic       mend;
    } t_packed_byte;

    // Bytes still owed by the block, oldest first
    t_packed_byte packed_byte_q[$];
    t_packed_byte want;

    // Register copies
    logic [16:0] poly_r;
    logic [4:0]  glen_r;
    logic        mode_r;
    logic [15:0] msg_len_r;

    // Packing state
    logic [63:0] bit_acc;
    int          bit_cnt;
    logic [15:0] byte_cnt;
    int          step_results;
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(string msg);
        if (fail_count < 100)
            $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [63:0] low_bits(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Queue one byte, dropping any beyond the per-request limit
    function automatic void queue_byte(logic [7:0] b, logic hdr);
        t_packed_byte item;
        if (step_results < cbp_pkg::MAX_RESULTS) begin
            item.data = b;
            item.hdr  = hdr;
            item.last = 1'b0;
            item.mend = 1'b0;
            packed_byte_q.insert(packed_byte_q.size(), item);
            step_results++;
        end
    endfunction

    // Append bits to the accumulator and send every full byte
    function automatic void shift_in(logic [63:0] bits, int len);
        bit_acc = (bit_acc << len) | (bits & low_bits(len));
        bit_cnt += len;
        while (bit_cnt >= 8) begin
            bit_cnt -= 8;
            queue_byte(8'(bit_acc >> bit_cnt), 1'b0);
            bit_acc &= low_bits(bit_cnt);
        end
    endfunction

    // Work out the packed bytes that one message byte produces
    function automatic void encode_message_byte(logic [7:0] data);
        int           r;
        int           w;
        int           words;
        int           pad;
        int           nbytes;
        int           tail_idx;
        logic [63:0]  gen;
        logic [63:0]  dw;
        logic [63:0]  rem;
        logic [15:0]  next_cnt;
        logic         ends;
        t_packed_byte tail;

        // clamp the generator length into the supported range
        if (glen_r < 2)
            r = 1;
        else if (glen_r > cbp_pkg::MAX_GEN_BITS_DEF)
            r = cbp_pkg::MAX_GEN_BITS_DEF - 1;
        else
            r = int'(glen_r) - 1;
        w = mode_r ? 8 : 4;
        words = 8 / w;
        step_results = 0;

        // open a message: header then leading zero pad
        if (byte_cnt == 0) begin
            nbytes = (msg_len_r == 0) ? (1 << cbp_pkg::LENGTH_BITS_DEF) : int'(msg_len_r);
            pad = 8 - ((nbytes * words * r) & 7);
            queue_byte(8'(pad), 1'b1);
            shift_in(64'd0, pad);
        end

        // one codeword per dataword, remainder by modulo-2 long division
        gen = (64'(poly_r) & low_bits(r + 1)) | (64'd1 << r);
        for (int k = 0; k < words; k++) begin
            dw = 64'(data >> (8 - w * (k + 1))) & low_bits(w);
            rem = dw << r;
            for (int i = w + r; i > r; i--) begin
                if (rem[i-1])
                    rem ^= gen << (i - 1 - r);
            end
            shift_in((dw << r) | (rem & low_bits(r)), w + r);
        end

        // close the message, flushing any leftover bits zero-filled
        next_cnt = byte_cnt + 16'd1;
        ends = (next_cnt == msg_len_r);
        if (ends) begin
            if (bit_cnt != 0)
                queue_byte(8'(bit_acc << (8 - bit_cnt)), 1'b0);
            bit_acc = '0;
            bit_cnt = 0;
            byte_cnt = '0;
        end else begin
            byte_cnt = next_cnt;
        end

        // mark the final byte of this request
        if (step_results > 0) begin
            tail_idx = packed_byte_q.size() - 1;
            tail = packed_byte_q[tail_idx];
            tail.last = 1'b1;
            tail.mend = ends;
            packed_byte_q[tail_idx] = tail;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poly_r    = 17'(cbp_pkg::GEN_POLY_RST);
            glen_r    = 5'(cbp_pkg::GEN_LEN_RST);
            mode_r    = 1'b0;
            msg_len_r = 16'(cbp_pkg::MSG_LEN_RST);
            bit_acc   = '0;
            bit_cnt   = 0;
            byte_cnt  = '0;
            packed_byte_q.delete();
        end else begin
            // follow register writes, check register reads
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (cbp_pkg::t_reg_idx'(paddr[3:2]))
                        cbp_pkg::REG_GEN_POLY:  poly_r    = pwdata[16:0];
                        cbp_pkg::REG_GEN_LEN:   glen_r    = pwdata[4:0];
                        cbp_pkg::REG_DW_MODE:   mode_r    = pwdata[0];
                        cbp_pkg::REG_MSG_BYTES: msg_len_r = pwdata[15:0];
                        default: ;
                    endcase
                end else begin
                    if ((cbp_pkg::t_reg_idx'(paddr[3:2]) == cbp_pkg::REG_GEN_POLY
                            && prdata !== 32'(poly_r))
                        || (cbp_pkg::t_reg_idx'(paddr[3:2]) == cbp_pkg::REG_GEN_LEN
                            && prdata !== 32'(glen_r))
                        || (cbp_pkg::t_reg_idx'(paddr[3:2]) == cbp_pkg::REG_DW_MODE
                            && prdata !== 32'(mode_r))
                        || (cbp_pkg::t_reg_idx'(paddr[3:2]) == cbp_pkg::REG_MSG_BYTES
                            && prdata !== 32'(msg_len_r)))
                        report_mismatch($sformatf("register read at %0h returned %08h",
                                                  paddr, prdata));
                end
            end

            // compare each delivered byte with the oldest prediction
            if (i_res_valid && !i_res_stall) begin
                if (packed_byte_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h hdr %0b last %0b end %0b",
                                              i_out_byte, i_is_header, i_last_of_run,
                                              i_message_end));
                end else begin
                    want = packed_byte_q.pop_front();
                    if (i_out_byte !== want.data || i_is_header !== want.hdr
                        || i_last_of_run !== want.last || i_message_end !== want.mend)
                        report_mismatch($sformatf(
                            "byte %02h hdr %0b last %0b end %0b, wanted %02h %0b %0b %0b",
                            i_out_byte, i_is_header, i_last_of_run, i_message_end,
                            want.data, want.hdr, want.last, want.mend));
                end
            end

            // predict the bytes of each accepted request
            if (i_in_valid && !i_in_stall)
                encode_message_byte(i_in_data);
        end
        o_outstanding <= packed_byte_q.size();
    end

endmodule

// ===== tb/tb_crc_codeword_byte_packer.sv =====
// Testbench top for the CRC codeword byte packer: clock, reset, register set-up
// and byte stimulus with random gaps and stalls; the verdict comes from cbp_checker.
// Depends on cbp_pkg, crc_codeword_byte_packer and cbp_checker.
module tb_crc_codeword_byte_packer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_is_header;
    logic        o_last_of_run;
    logic        o_message_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    bit send_idling = 1'b1;
    bit sink_idling = 1'b1;

    crc_codeword_byte_packer dut (.*);

    cbp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_data     (i_data_byte),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_out_byte    (o_out_byte),
        .i_is_header   (o_is_header),
        .i_last_of_run (o_last_of_run),
        .i_message_end (o_message_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // stall the result channel at random
    always @(posedge i_clk) begin
        i_stall <= sink_idling && ($urandom_range(99) < 24);
    end

    // end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // offer one byte, with random gaps, and hold it until accepted
    task automatic send_byte(logic [7:0] b);
        while (send_idling && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    // setup phase, access phase, then the port released before returning
    task automatic reg_access(bit wr, cbp_pkg::t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(cbp_pkg::t_reg_idx idx, logic [31:0] val);
        reg_access(1'b1, idx, val);
    endtask

    task automatic read_all_regs();
        reg_access(1'b0, cbp_pkg::REG_GEN_POLY, '0);
        reg_access(1'b0, cbp_pkg::REG_GEN_LEN, '0);
        reg_access(1'b0, cbp_pkg::REG_DW_MODE, '0);
        reg_access(1'b0, cbp_pkg::REG_MSG_BYTES, '0);
    endtask

    // drop valid and wait until every predicted byte has come out
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] poly, logic [31:0] glen, logic [31:0] mode,
                           logic [31:0] len);
        reg_write(cbp_pkg::REG_GEN_POLY, poly);
        reg_write(cbp_pkg::REG_GEN_LEN, glen);
        reg_write(cbp_pkg::REG_DW_MODE, mode);
        reg_write(cbp_pkg::REG_MSG_BYTES, len);
        read_all_regs();
    endtask

    initial begin
        int random_sent;
        int msg_pos;
        int len_v;
        int glen_v;
        int n_bytes;
        int msgs;

        // hold reset, then check the reset values
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_all_regs();

        // reset settings: one-byte messages
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        // 8-bit datawords, stream already byte aligned: pad of eight
        set_all(32'h107, 9, 1, 2);
        send_byte(8'h80);
        send_byte(8'h7F);
        settle();

        // generator length below two, all-zero generator
        set_all(32'h0, 0, 0, 3);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hFF);
        settle();

        // generator length above the maximum, all-ones generator, most bytes out
        set_all(32'h1FFFF, 31, 0, 2);
        send_byte(8'hFF);
        send_byte(8'h01);
        settle();

        // generator length of one
        set_all(32'h1, 1, 1, 1);
        send_byte(8'h80);
        settle();

        // change the generator mid-message to leave bits over at the end
        set_all(32'd13, 4, 0, 2);
        send_byte(8'h3C);
        settle();
        reg_write(cbp_pkg::REG_GEN_LEN, 5);
        reg_write(cbp_pkg::REG_GEN_POLY, 32'h13);
        send_byte(8'hC3);
        settle();

        // longest message length, then shortened while still above the count
        set_all(32'h1D, 5, 0, 16'hFFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();
        reg_write(cbp_pkg::REG_MSG_BYTES, 3);
        send_byte(8'h96);
        settle();

        // zero length means the full count; then close the message at 45 bytes
        // with a long stretch of no gaps or stalls
        set_all(32'h3, 2, 1, 0);
        repeat (5) send_byte(8'($urandom_range(0, 255)));
        settle();
        reg_write(cbp_pkg::REG_MSG_BYTES, 45);
        send_idling = 1'b0;
        sink_idling = 1'b0;
        repeat (40) send_byte(8'($urandom_range(0, 255)));
        settle();

        // random phases: mostly whole messages, some cut short before a change
        random_sent = 0;
        msg_pos = 0;
        while (random_sent < 250) begin
            send_idling = ($urandom_range(5) != 0);
            sink_idling = ($urandom_range(5) != 0);
            glen_v = ($urandom_range(3) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 17);
            len_v = ($urandom_range(9) == 0) ? msg_pos + $urandom_range(1, 20)
                                              : msg_pos + $urandom_range(1, 6);
            case ($urandom_range(5))
                0: reg_write(cbp_pkg::REG_GEN_POLY, 32'h0);
                1: reg_write(cbp_pkg::REG_GEN_POLY, 32'h1FFFF);
                default: reg_write(cbp_pkg::REG_GEN_POLY, $urandom_range(0, 131071));
            endcase
            reg_write(cbp_pkg::REG_GEN_LEN, glen_v);
            reg_write(cbp_pkg::REG_DW_MODE, $urandom_range(1));
            reg_write(cbp_pkg::REG_MSG_BYTES, len_v);
            if ($urandom_range(3) == 0)
                read_all_regs();

            msgs = $urandom_range(1, 3);
            n_bytes = (len_v - msg_pos) + (msgs - 1) * len_v;
            if ($urandom_range(4) == 0)
                n_bytes = $urandom_range(1, n_bytes);
            repeat (n_bytes) begin
                send_byte(8'($urandom_range(0, 255)));
                msg_pos = (msg_pos + 1 == len_v) ? 0 : msg_pos + 1;
            end
            random_sent += n_bytes;
            settle();
        end

        settle();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
